[design/bsplc_pkg.sv]
// Shared constants, types and helper functions for the button press classifier.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package bsplc_pkg;

  localparam int BUTTONS = 3;
  localparam int NOW_W = 32;
  localparam int LEVEL_W = 3;
  localparam int EVT_W = 3;
  localparam int TH_W = 16;

  localparam logic [NOW_W-1:0] SHORT_MIN_MS = NOW_W'(30);
  localparam logic [TH_W-1:0] LONG_PRESS_RESET = TH_W'(1000);
  localparam logic [EVT_W-1:0] EVT_NONE = '0;

  typedef struct packed {
    logic fire;
    logic short_hit;
  } lane_stat_t;

  function automatic logic [EVT_W-1:0] short_code(input int idx);
    return EVT_W'(idx + 1);
  endfunction

  function automatic logic [EVT_W-1:0] long_code(input int idx);
    return EVT_W'(BUTTONS + 1 + idx);
  endfunction

endpackage

[design/bsplc_if.sv]
// Valid/ready channel interfaces for polls, events and the threshold register.
// Depends on bsplc_pkg for the field widths.
`timescale 1ns / 1ps

interface bsplc_in_if;
  import bsplc_pkg::*;
  logic valid;
  logic ready;
  logic [NOW_W-1:0] now_ms;
  logic [LEVEL_W-1:0] buttons_down;
  modport source (output valid, output now_ms, output buttons_down, input ready);
  modport sink (input valid, input now_ms, input buttons_down, output ready);
endinterface

interface bsplc_out_if;
  import bsplc_pkg::*;
  logic valid;
  logic ready;
  logic [EVT_W-1:0] event_code;
  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

interface bsplc_cfg_if;
  import bsplc_pkg::*;
  logic valid;
  logic ready;
  logic [TH_W-1:0] long_thresh;
  modport source (output valid, output long_thresh, input ready);
  modport sink (input valid, input long_thresh, output ready);
endinterface

[design/bsplc_lane.sv]
// One button lane: press time, level and long flag, plus the edge and timing checks.
// Depends on bsplc_pkg.
`timescale 1ns / 1ps

module bsplc_lane
  import bsplc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NOW_W-1:0] now_ms,
  input  logic             down,
  input  logic [TH_W-1:0]  long_thresh,
  input  logic             commit,
  output lane_stat_t       stat
);

  logic [NOW_W-1:0] press_time_r;
  logic             was_down_r;
  logic             long_done_r;
  logic [NOW_W-1:0] elapsed;
  logic             press_edge;
  logic             held;
  logic             release_edge;

  assign elapsed      = now_ms - press_time_r;
  assign press_edge   = down & ~was_down_r;
  assign held         = down & was_down_r;
  assign release_edge = ~down & was_down_r;

  assign stat.fire = held & ~long_done_r &
                     (elapsed >= {{(NOW_W-TH_W){1'b0}}, long_thresh});
  assign stat.short_hit = release_edge & ~long_done_r & (elapsed >= SHORT_MIN_MS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_time_r <= '0;
      was_down_r   <= 1'b0;
      long_done_r  <= 1'b0;
    end else if (commit) begin
      was_down_r <= down;
      if (press_edge) begin
        press_time_r <= now_ms;
        long_done_r  <= 1'b0;
      end else if (stat.fire) begin
        long_done_r <= 1'b1;
      end
    end
  end

endmodule

[design/bsplc_merge.sv]
// Merging stage: first long event wins and blocks later lanes; last short release goes out or waits.
// Holds the pending short event behind a long event. Depends on bsplc_pkg.
`timescale 1ns / 1ps

module bsplc_merge
  import bsplc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  lane_stat_t       stat [BUTTONS],
  output logic [BUTTONS-1:0] commit,
  output logic [EVT_W-1:0] event_code
);

  logic [EVT_W-1:0] pending_r;
  logic [EVT_W-1:0] pending_nxt;

  always_comb begin
    logic             blocked;
    logic [EVT_W-1:0] pend;
    logic [EVT_W-1:0] lcode;
    blocked = 1'b0;
    pend    = pending_r;
    lcode   = EVT_NONE;
    commit  = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      if (!blocked) begin
        commit[i] = accept;
        if (stat[i].fire) begin
          lcode   = long_code(i);
          blocked = 1'b1;
        end else if (stat[i].short_hit) begin
          pend = short_code(i);
        end
      end
    end
    event_code  = blocked ? lcode : pend;
    pending_nxt = blocked ? pend : EVT_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= EVT_NONE;
    end else if (accept) begin
      pending_r <= pending_nxt;
    end
  end

endmodule

[design/button_short_long_press_classifier_core.sv]
// Button short/long press classifier: one lane per button, a merging stage, an output register.
// Each event shows in the cycle after its poll transfer; one poll per cycle unless output stalls.
// The output register refills in the same cycle its event is taken, so polls stream back to back.
// Synchronous active-low reset clears all lanes, the pending event and the output valid,
// and sets the long press threshold to 1000 ms. Depends on bsplc_pkg, the interfaces,
// bsplc_lane and bsplc_merge.
`timescale 1ns / 1ps

module button_short_long_press_classifier_core
  import bsplc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  bsplc_in_if.sink    in_ch,
  bsplc_out_if.source out_ch,
  bsplc_cfg_if.sink   cfg_ch
);

  logic [TH_W-1:0]    long_thresh_r;
  logic               out_valid_r;
  logic [EVT_W-1:0]   out_code_r;
  logic               accept;
  lane_stat_t         stat [BUTTONS];
  logic [BUTTONS-1:0] commit;
  logic [EVT_W-1:0]   event_code;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign accept       = in_ch.valid & in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_code_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_thresh_r <= LONG_PRESS_RESET;
    end else if (cfg_ch.valid) begin
      long_thresh_r <= cfg_ch.long_thresh;
    end
  end

  for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
    logic lane_down;
    if (g < LEVEL_W) begin : g_pin
      assign lane_down = in_ch.buttons_down[g];
    end else begin : g_nopin
      assign lane_down = 1'b0;
    end

    bsplc_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .now_ms      (in_ch.now_ms),
      .down        (lane_down),
      .long_thresh (long_thresh_r),
      .commit      (commit[g]),
      .stat        (stat[g])
    );
  end

  bsplc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .stat       (stat),
    .commit     (commit),
    .event_code (event_code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_code_r <= event_code;
    end
  end

`ifndef SYNTH
  // Every accepted poll produces an event in the next cycle.
  a_accept_gives_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted poll did not produce an event");

  // A stalled event is not overwritten by a new poll.
  a_stall_holds_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.event_code))
    else $error("stalled event changed");

  // Reset leaves no event on the output.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("event valid after reset");
`endif

endmodule
